FILE: hw/rtl/quantized_int8_dot_product_requant_assert.svh
// Assertion macros for the checker of the dot product block.
`ifndef QUANTIZED_INT8_DOT_PRODUCT_REQUANT_ASSERT_SVH
`define QUANTIZED_INT8_DOT_PRODUCT_REQUANT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define QDP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define QDP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/qdp_pkg.sv
// Shared types and constants of the quantized dot product block.
`default_nettype none

package qdp_pkg;

	// Accumulator width and its saturation limits.
	localparam int ACC_W = 40;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Largest magnitude kept after scaling; anything above clamps anyway.
	localparam int BIG_MAG = 4096;

	// Output clamp limits.
	localparam logic signed [15:0] Y_SMIN = -16'sd128;
	localparam logic signed [15:0] Y_SMAX = 16'sd127;
	localparam logic signed [15:0] Y_UMIN = 16'sd0;
	localparam logic signed [15:0] Y_UMAX = 16'sd255;

	// Default depth of the queue between front and back.
	localparam int Q_DEPTH = 4;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_A_ZP    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B_ZP    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_ZP    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A_SGN   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B_SGN   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SGN   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MULT    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT   = 4'd7;

	// Configuration register file contents.
	typedef struct packed {
		logic signed [8:0] a_zero_point;
		logic signed [8:0] b_zero_point;
		logic signed [8:0] y_zero_point;
		logic              a_is_signed;
		logic              b_is_signed;
		logic              y_is_signed;
		logic [31:0]       scale_multiplier;
		logic [5:0]        scale_shift;
	} cfg_t;

	// Queue room status seen by the front.
	typedef struct packed {
		logic free1;
		logic free2;
	} qstat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/qdp_fifo.sv
// Short queue of finished accumulator sums between front and back.
`default_nettype none

module qdp_fifo #(
	parameter int DEPTH = qdp_pkg::Q_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [qdp_pkg::ACC_W-1:0]  push_data,
	input  logic                       pop,
	output logic [qdp_pkg::ACC_W-1:0]  pop_data,
	output logic                       empty,
	output qdp_pkg::qstat_t            stat
);
	import qdp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [ACC_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// Entry storage, written at the write pointer.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign pop_data   = mem_q[rd_ptr_q];
	assign empty      = (count_q == '0);
	assign stat.free1 = (32'(count_q) + 1 <= DEPTH);
	assign stat.free2 = (32'(count_q) + 2 <= DEPTH);

endmodule

`default_nettype wire

FILE: hw/rtl/qdp_front.sv
// Front end: accepts term requests, multiplies and accumulates with saturation.
`default_nettype none

module qdp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  qdp_pkg::cfg_t              cfg,
	input  qdp_pkg::qstat_t            qstat,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 a_byte,
	input  logic [7:0]                 b_byte,
	input  logic                       last_term,
	output logic                       push,
	output logic [qdp_pkg::ACC_W-1:0]  push_data
);
	import qdp_pkg::*;

	logic signed [8:0]       ax;
	logic signed [8:0]       bx;
	logic signed [9:0]       av;
	logic signed [9:0]       bv;
	logic signed [19:0]      prod;
	logic                    accept;
	logic                    vld_s1;
	logic                    last_s1;
	logic signed [19:0]      prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W:0]   sum;
	logic signed [ACC_W-1:0] sat;

	// Operand decode: widen each byte by its signedness, then remove the zero point.
	assign ax   = {cfg.a_is_signed & a_byte[7], a_byte};
	assign bx   = {cfg.b_is_signed & b_byte[7], b_byte};
	assign av   = {ax[8], ax} - {cfg.a_zero_point[8], cfg.a_zero_point};
	assign bv   = {bx[8], bx} - {cfg.b_zero_point[8], cfg.b_zero_point};
	assign prod = av * bv;

	// A sum is pushed to the queue in the cycle after its last term is taken, so keep room for it.
	assign in_ready = last_s1 ? qstat.free2 : qstat.free1;
	assign accept   = in_valid & in_ready;

	// Product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			last_s1 <= accept & last_term;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= prod;
		end
	end

	// Accumulate stage with saturation at the 40-bit limits.
	assign sum = {acc_q[ACC_W-1], acc_q} + {{(ACC_W + 1 - 20){prod_s1[19]}}, prod_s1};

	always_comb begin
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sat = sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= last_s1 ? '0 : sat;
		end
	end

	assign push      = vld_s1 & last_s1;
	assign push_data = sat;

endmodule

`default_nettype wire

FILE: hw/rtl/qdp_back.sv
// Back end: scales a finished sum, rounds half to even, offsets and clamps.
`default_nettype none

module qdp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  qdp_pkg::cfg_t              cfg,
	input  logic                       q_empty,
	input  logic [qdp_pkg::ACC_W-1:0]  q_data,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 y_byte
);
	import qdp_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LO    = 3'd1;
	localparam logic [2:0] ST_HI    = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_SHIFT = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]        state_q;
	logic              neg_q;
	logic [ACC_W-1:0]  mag_q;
	logic [63:0]       plo_q;
	logic [39:0]       phi_q;
	logic [71:0]       full_q;
	logic [71:0]       q_q;
	logic              inc_q;
	logic              out_valid_q;
	logic [7:0]        y_q;

	logic [71:0]       shifted;
	logic [5:0]        sm1;
	logic [71:0]       lowmask;
	logic              rbit;
	logic              sticky;
	logic              inc;
	logic [13:0]       qi;
	logic              big;
	logic [12:0]       mag13;
	logic signed [15:0] mag16;
	logic signed [15:0] ys;
	logic signed [15:0] y;
	logic signed [15:0] lo_lim;
	logic signed [15:0] hi_lim;
	logic signed [15:0] yc;
	logic              load;

	// Round half to even: the round bit, the bits below it, and the kept LSB.
	assign shifted = full_q >> cfg.scale_shift;
	assign sm1     = cfg.scale_shift - 6'd1;
	assign lowmask = (72'd1 << sm1) - 72'd1;
	assign rbit    = full_q[7'(sm1)];
	assign sticky  = |(full_q & lowmask);
	assign inc     = (cfg.scale_shift != 6'd0) & rbit & (sticky | shifted[0]);

	// Cap the magnitude, restore the sign, add the output zero point and clamp.
	assign qi     = {1'b0, q_q[12:0]} + 14'(inc_q);
	assign big    = (|q_q[71:13]) | (qi > 14'(BIG_MAG));
	assign mag13  = big ? 13'(BIG_MAG) : qi[12:0];
	assign mag16  = {3'b000, mag13};
	assign ys     = neg_q ? -mag16 : mag16;
	assign y      = ys + {{7{cfg.y_zero_point[8]}}, cfg.y_zero_point};
	assign lo_lim = cfg.y_is_signed ? Y_SMIN : Y_UMIN;
	assign hi_lim = cfg.y_is_signed ? Y_SMAX : Y_UMAX;

	always_comb begin
		if (y < lo_lim) begin
			yc = lo_lim;
		end else if (y > hi_lim) begin
			yc = hi_lim;
		end else begin
			yc = y;
		end
	end

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Sequencer over the split multiply, the rounding shift and the output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_LO;
					end
				end
				ST_LO:    state_q <= ST_HI;
				ST_HI:    state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_SHIFT;
				ST_SHIFT: state_q <= ST_OUT;
				ST_OUT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, one partial product per cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				neg_q <= q_data[ACC_W-1];
				mag_q <= q_data[ACC_W-1] ? (~q_data + ACC_W'(1)) : q_data;
			end
			ST_LO: begin
				plo_q <= 64'(mag_q[31:0]) * 64'(cfg.scale_multiplier);
			end
			ST_HI: begin
				phi_q <= 40'(mag_q[ACC_W-1:32]) * 40'(cfg.scale_multiplier);
			end
			ST_SUM: begin
				full_q <= {8'd0, plo_q} + {phi_q, 32'd0};
			end
			ST_SHIFT: begin
				q_q   <= shifted;
				inc_q <= inc;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			y_q <= yc[7:0];
		end
	end

	assign out_valid = out_valid_q;
	assign y_byte    = y_q;

endmodule

`default_nettype wire

FILE: hw/rtl/quantized_int8_dot_product_requant.sv
// Quantized int8 dot product with requantization to one output byte.
//
// Input channel (in_valid/in_ready): one request per term, carrying a_byte,
// b_byte and last_term. Terms are taken one per cycle while the sum queue
// has room. The request that carries last_term closes the dot product.
// Output channel (out_valid/out_ready): one y_byte per closed dot product.
// Sums pass the product stage, queue, back end and output register. The back
// end takes one sum at a time: its 40 by 32 bit scale product is formed as
// two partial products in successive cycles, then added, rounded half to even,
// offset and clamped. Closed sums wait in a queue of DEPTH entries, so short
// dot products are taken at full rate until it fills.
// A stalled receiver holds the result in the output register; the back end
// then stops, the queue fills, and in_ready drops.
// Reset clears the accumulator, the queue, the output valid flag and all
// configuration registers. Configuration writes land at once and should be
// made only while the block is idle.
`default_nettype none

module quantized_int8_dot_product_requant #(
	parameter int DEPTH = qdp_pkg::Q_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [qdp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qdp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      a_byte,
	input  logic [7:0]                      b_byte,
	input  logic                            last_term,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      y_byte
);
	import qdp_pkg::*;

	cfg_t             cfg_q;
	qstat_t           qstat;
	logic             push;
	logic [ACC_W-1:0] push_data;
	logic             pop;
	logic [ACC_W-1:0] pop_data;
	logic             q_empty;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A_ZP:  cfg_q.a_zero_point     <= cfg_data[8:0];
				REG_B_ZP:  cfg_q.b_zero_point     <= cfg_data[8:0];
				REG_Y_ZP:  cfg_q.y_zero_point     <= cfg_data[8:0];
				REG_A_SGN: cfg_q.a_is_signed      <= cfg_data[0];
				REG_B_SGN: cfg_q.b_is_signed      <= cfg_data[0];
				REG_Y_SGN: cfg_q.y_is_signed      <= cfg_data[0];
				REG_MULT:  cfg_q.scale_multiplier <= cfg_data[31:0];
				REG_SHIFT: cfg_q.scale_shift      <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	qdp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a_byte    (a_byte),
		.b_byte    (b_byte),
		.last_term (last_term),
		.push      (push),
		.push_data (push_data)
	);

	qdp_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty),
		.stat      (qstat)
	);

	qdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.y_byte    (y_byte)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/qdp_checker.sv
// Port-level checker for the dot product block, bound to the top level.
`default_nettype none

`include "quantized_int8_dot_product_requant_assert.svh"

module qdp_checker #(
	parameter int DEPTH = qdp_pkg::Q_DEPTH
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       last_term,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] y_byte
);
	localparam int PW = $clog2(DEPTH + 4) + 1;

	logic [PW-1:0] pending_q;
	logic          in_last;
	logic          out_take;

	assign in_last  = in_valid & in_ready & last_term;
	assign out_take = out_valid & out_ready;

	// Dot products closed at the input but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_last && !out_take) begin
			pending_q <= pending_q + PW'(1);
		end else if (out_take && !in_last) begin
			pending_q <= pending_q - PW'(1);
		end
	end

	// A stalled result stays put.
	`QDP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(y_byte), "result dropped or changed while stalled")

	// No result without a closed dot product behind it.
	`QDP_ASSERT_IMP(a_no_spurious, out_valid, pending_q != '0, "result with no closing term")

	// Backlog is bounded by the queue, the product stage, the back end and the output register.
	`QDP_ASSERT_IMP(a_backlog, 1'b1, 32'(pending_q) <= DEPTH + 2, "backlog exceeds queue capacity")

endmodule

bind quantized_int8_dot_product_requant qdp_checker #(
	.DEPTH (DEPTH)
) u_qdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last_term (last_term),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.y_byte    (y_byte)
);

`default_nettype wire
